/* hw/rtl/qmn_pkg.sv */
package qmn_pkg;

   // Width and reset value of the zero threshold register (Q2.60).
   localparam int THRESH_W = 62;
   localparam logic [THRESH_W-1:0] THRESH_RESET = 62'd11529215046;

   // The threshold is held with this many fraction bits.
   localparam int THRESH_FRAC = 60;

   typedef enum logic {
      OP_MULTIPLY  = 1'b0,
      OP_NORMALIZE = 1'b1
   } op_type;

   // Pipeline control shared by the top level and the pipelined root and divider units.
   typedef struct packed {
      logic enable;
   } qmn_ctl_type;

   // Hamilton product terms, components ordered x, y, z, w.
   // Each output component is the sum of four left*right products.
   typedef int unsigned term_idx_type [4][4];
   typedef bit          term_neg_type [4][4];

   localparam term_idx_type HAM_L = '{'{3, 0, 1, 2}, '{3, 0, 1, 2},
                                      '{3, 0, 1, 2}, '{3, 0, 1, 2}};
   localparam term_idx_type HAM_R = '{'{0, 3, 2, 1}, '{1, 2, 3, 0},
                                      '{2, 1, 0, 3}, '{3, 0, 1, 2}};
   localparam term_neg_type HAM_NEG = '{'{0, 0, 0, 1}, '{0, 1, 0, 0},
                                        '{0, 0, 1, 0}, '{0, 1, 1, 1}};

endpackage

/* hw/rtl/qmn_isqrt.sv */
// Pipelined integer square root, one root bit resolved per stage.
module qmn_isqrt #(
   parameter int ROOT_W = 37
) (
   input  logic                  clock,
   input  qmn_pkg::qmn_ctl_type  ctl,
   input  logic [2*ROOT_W-1:0]   radicand,
   output logic [ROOT_W-1:0]     root
);

   localparam int SQ_W = 2 * ROOT_W;

   logic [SQ_W:0]     rem_ff  [ROOT_W];
   logic [ROOT_W-1:0] root_ff [ROOT_W];

   for (genvar k = 0; k < ROOT_W; k++) begin : g_stage
      localparam int B = ROOT_W - 1 - k;
      logic [SQ_W:0]     rem_prev;
      logic [ROOT_W-1:0] root_prev;
      logic [SQ_W:0]     trial;
      logic [SQ_W:0]     rem_in;
      logic [ROOT_W-1:0] root_in;

      if (k == 0) begin : g_first
         assign rem_prev  = {1'b0, radicand};
         assign root_prev = '0;
      end else begin : g_next
         assign rem_prev  = rem_ff[k-1];
         assign root_prev = root_ff[k-1];
      end

      // (root + 2^B)^2 - root^2 = root * 2^(B+1) + 2^(2B).
      assign trial = ({{(SQ_W+1-ROOT_W){1'b0}}, root_prev} << (B + 1))
                   + ((SQ_W+1)'(1) << (2 * B));

      always_comb begin
         if (rem_prev >= trial) begin
            rem_in  = rem_prev - trial;
            root_in = root_prev | (ROOT_W'(1) << B);
         end else begin
            rem_in  = rem_prev;
            root_in = root_prev;
         end
      end

      always_ff @(posedge clock) begin
         if (ctl.enable) begin
            rem_ff[k]  <= rem_in;
            root_ff[k] <= root_in;
         end
      end
   end

   assign root = root_ff[ROOT_W-1];

endmodule

/* hw/rtl/qmn_divide.sv */
// Pipelined restoring divider, one quotient bit resolved per stage.
// The caller guarantees that the quotient fits in QUO_W bits.
module qmn_divide #(
   parameter int NUM_W = 68,
   parameter int DEN_W = 38,
   parameter int QUO_W = 31
) (
   input  logic                  clock,
   input  qmn_pkg::qmn_ctl_type  ctl,
   input  logic [NUM_W-1:0]      numer,
   input  logic [DEN_W-1:0]      denom,
   output logic [QUO_W-1:0]      quot
);

   localparam int WK_W = ((NUM_W > DEN_W + QUO_W) ? NUM_W : DEN_W + QUO_W) + 1;

   logic [WK_W-1:0]  rem_ff [QUO_W];
   logic [DEN_W-1:0] den_ff [QUO_W];
   logic [QUO_W-1:0] quo_ff [QUO_W];

   for (genvar k = 0; k < QUO_W; k++) begin : g_stage
      localparam int B = QUO_W - 1 - k;
      logic [WK_W-1:0]  rem_prev;
      logic [DEN_W-1:0] den_prev;
      logic [QUO_W-1:0] quo_prev;
      logic [WK_W-1:0]  sub;
      logic [WK_W-1:0]  rem_in;
      logic [QUO_W-1:0] quo_in;

      if (k == 0) begin : g_first
         assign rem_prev = {{(WK_W-NUM_W){1'b0}}, numer};
         assign den_prev = denom;
         assign quo_prev = '0;
      end else begin : g_next
         assign rem_prev = rem_ff[k-1];
         assign den_prev = den_ff[k-1];
         assign quo_prev = quo_ff[k-1];
      end

      assign sub = {{(WK_W-DEN_W){1'b0}}, den_prev} << B;

      always_comb begin
         if (rem_prev >= sub) begin
            rem_in = rem_prev - sub;
            quo_in = quo_prev | (QUO_W'(1) << B);
         end else begin
            rem_in = rem_prev;
            quo_in = quo_prev;
         end
      end

      always_ff @(posedge clock) begin
         if (ctl.enable) begin
            rem_ff[k] <= rem_in;
            den_ff[k] <= den_prev;
            quo_ff[k] <= quo_in;
         end
      end
   end

   assign quot = quo_ff[QUO_W-1];

endmodule

/* hw/rtl/quaternion_multiply_normalize.sv */
// Throughput: one request per cycle unless the result side stalls; the root and divider units resolve one bit a stage.
// A stall at the result side freezes every stage together, so nothing is lost.
// Reset (synchronous, active high) empties the pipeline and restores the threshold.
// The threshold register itself holds its value across requests until rewritten.
module quaternion_multiply_normalize #(
   parameter int COMPONENT_WIDTH = 32
) (
   input  logic                                   clock,
   input  logic                                   reset,

   input  logic                                   req_valid,
   output logic                                   req_ready,
   input  logic                                   req_opcode,
   input  logic signed [COMPONENT_WIDTH-1:0]      req_left_x,
   input  logic signed [COMPONENT_WIDTH-1:0]      req_left_y,
   input  logic signed [COMPONENT_WIDTH-1:0]      req_left_z,
   input  logic signed [COMPONENT_WIDTH-1:0]      req_left_w,
   input  logic signed [COMPONENT_WIDTH-1:0]      req_right_x,
   input  logic signed [COMPONENT_WIDTH-1:0]      req_right_y,
   input  logic signed [COMPONENT_WIDTH-1:0]      req_right_z,
   input  logic signed [COMPONENT_WIDTH-1:0]      req_right_w,

   output logic                                   rsp_valid,
   input  logic                                   rsp_ready,
   output logic signed [COMPONENT_WIDTH-1:0]      rsp_out_x,
   output logic signed [COMPONENT_WIDTH-1:0]      rsp_out_y,
   output logic signed [COMPONENT_WIDTH-1:0]      rsp_out_z,
   output logic signed [COMPONENT_WIDTH-1:0]      rsp_out_w,
   output logic                                   rsp_degenerate,

   input  logic                                   csr_write_enable,
   input  logic [qmn_pkg::THRESH_W-1:0]           csr_write_data
);

   // Component width W carries F = W-2 fraction bits.
   localparam int W     = COMPONENT_WIDTH;
   localparam int F     = W - 2;
   localparam int ACC_W = 2 * W + 2;     // exact sum of four products
   localparam int V_W   = W + 4;         // rounded product component, signed
   localparam int SQ_W  = 2 * V_W;       // one square
   localparam int ROOT_W = V_W + 1;      // integer root of the magnitude sum
   localparam int S_W   = 2 * ROOT_W;    // magnitude squared, 2F fraction bits
   localparam int NUM_W = V_W + F + 2;   // |v| * 2^(F+1) + root
   localparam int DEN_W = ROOT_W + 1;    // 2 * root
   localparam int QUO_W = F + 1;         // |v| <= root, so quotient <= 2^F
   localparam int NST   = 5 + ROOT_W + QUO_W + 1;

   // The threshold has 60 fraction bits; align it with the sum's 2F.
   localparam int LSH_S = (2 * F >= qmn_pkg::THRESH_FRAC) ? 0 : qmn_pkg::THRESH_FRAC - 2 * F;
   localparam int LSH_T = (2 * F >= qmn_pkg::THRESH_FRAC) ? 2 * F - qmn_pkg::THRESH_FRAC : 0;
   localparam int CMP_W = S_W + qmn_pkg::THRESH_W + 64;

   qmn_pkg::qmn_ctl_type ctl;
   logic                 enable;

   // All stages advance together whenever the output register can move.
   logic [NST-1:0] vld_ff;
   assign enable     = ~vld_ff[NST-1] | rsp_ready;
   assign ctl.enable = enable;
   assign req_ready  = enable;
   assign rsp_valid  = vld_ff[NST-1];

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (enable) begin
         vld_ff <= {vld_ff[NST-2:0], req_valid};
      end
   end

   // Threshold register.
   logic [qmn_pkg::THRESH_W-1:0] thresh_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         thresh_ff <= qmn_pkg::THRESH_RESET;
      end else if (csr_write_enable) begin
         thresh_ff <= csr_write_data;
      end
   end

   logic signed [W-1:0] left_c  [4];
   logic signed [W-1:0] right_c [4];

   assign left_c  = '{req_left_x, req_left_y, req_left_z, req_left_w};
   assign right_c = '{req_right_x, req_right_y, req_right_z, req_right_w};

   // Stage 1: the sixteen partial products of the Hamilton product.
   logic signed [2*W-1:0] prod_ff [4][4];
   logic signed [W-1:0]   left1_ff [4];
   logic                  norm1_ff;

   always_ff @(posedge clock) begin
      if (enable) begin
         for (int c = 0; c < 4; c++) begin
            for (int t = 0; t < 4; t++) begin
               prod_ff[c][t] <= left_c[qmn_pkg::HAM_L[c][t]] * right_c[qmn_pkg::HAM_R[c][t]];
            end
            left1_ff[c] <= left_c[c];
         end
         norm1_ff <= (req_opcode == qmn_pkg::OP_NORMALIZE);
      end
   end

   // Stage 2: sum, round half up, drop F fraction bits (normalize: left operand as is), split sign and magnitude.
   logic           neg2_ff [4];
   logic [V_W-1:0] mag2_ff [4];

   for (genvar c = 0; c < 4; c++) begin : g_sum
      logic signed [ACC_W-1:0] acc;
      logic signed [V_W-1:0]   vec;

      always_comb begin
         acc = ACC_W'(1) <<< (F - 1);
         for (int t = 0; t < 4; t++) begin
            if (qmn_pkg::HAM_NEG[c][t]) begin
               acc = acc - ACC_W'(prod_ff[c][t]);
            end else begin
               acc = acc + ACC_W'(prod_ff[c][t]);
            end
         end
         if (norm1_ff) begin
            vec = V_W'(left1_ff[c]);
         end else begin
            vec = acc[ACC_W-1:F];
         end
      end

      always_ff @(posedge clock) begin
         if (enable) begin
            neg2_ff[c] <= vec[V_W-1];
            mag2_ff[c] <= vec[V_W-1] ? V_W'(-vec) : V_W'(vec);
         end
      end
   end

   // Stage 3: squares. Stage 4: their sum. Stage 5: threshold compare.
   logic [SQ_W-1:0] sq3_ff  [4];
   logic [V_W-1:0]  mag3_ff [4];
   logic            neg3_ff [4];
   logic [S_W-1:0]  s4_ff;
   logic [V_W-1:0]  mag4_ff [4];
   logic            neg4_ff [4];
   logic [S_W-1:0]  s5_ff;
   logic            deg5_ff;
   logic [V_W-1:0]  mag5_ff [4];
   logic            neg5_ff [4];

   logic [CMP_W-1:0] s_cmp;
   logic [CMP_W-1:0] t_cmp;

   assign s_cmp = {{(CMP_W-S_W){1'b0}}, s4_ff} << LSH_S;
   assign t_cmp = {{(CMP_W-qmn_pkg::THRESH_W){1'b0}}, thresh_ff} << LSH_T;

   always_ff @(posedge clock) begin
      if (enable) begin
         for (int c = 0; c < 4; c++) begin
            sq3_ff[c]  <= SQ_W'(mag2_ff[c]) * SQ_W'(mag2_ff[c]);
            mag3_ff[c] <= mag2_ff[c];
            neg3_ff[c] <= neg2_ff[c];
            mag4_ff[c] <= mag3_ff[c];
            neg4_ff[c] <= neg3_ff[c];
            mag5_ff[c] <= mag4_ff[c];
            neg5_ff[c] <= neg4_ff[c];
         end
         s4_ff   <= S_W'(sq3_ff[0]) + S_W'(sq3_ff[1]) + S_W'(sq3_ff[2]) + S_W'(sq3_ff[3]);
         s5_ff   <= s4_ff;
         deg5_ff <= (s_cmp <= t_cmp);
      end
   end

   // Square root of the magnitude sum.
   logic [ROOT_W-1:0] root;

   qmn_isqrt #(
      .ROOT_W(ROOT_W)
   ) u_isqrt (
      .clock    (clock),
      .ctl      (ctl),
      .radicand (s5_ff),
      .root     (root)
   );

   // Side data follows the root unit, then the degenerate flag and signs the divider.
   logic [V_W-1:0] mag_sq_ff [ROOT_W][4];
   logic           neg_sq_ff [ROOT_W][4];
   logic           deg_sq_ff [ROOT_W];
   logic           neg_dv_ff [QUO_W][4];
   logic           deg_dv_ff [QUO_W];

   always_ff @(posedge clock) begin
      if (enable) begin
         mag_sq_ff[0] <= mag5_ff;
         neg_sq_ff[0] <= neg5_ff;
         deg_sq_ff[0] <= deg5_ff;
         for (int k = 1; k < ROOT_W; k++) begin
            mag_sq_ff[k] <= mag_sq_ff[k-1];
            neg_sq_ff[k] <= neg_sq_ff[k-1];
            deg_sq_ff[k] <= deg_sq_ff[k-1];
         end
         neg_dv_ff[0] <= neg_sq_ff[ROOT_W-1];
         deg_dv_ff[0] <= deg_sq_ff[ROOT_W-1];
         for (int k = 1; k < QUO_W; k++) begin
            neg_dv_ff[k] <= neg_dv_ff[k-1];
            deg_dv_ff[k] <= deg_dv_ff[k-1];
         end
      end
   end

   // Each magnitude times 2^F over the root, rounded half away from zero.
   logic [QUO_W-1:0] quot [4];
   logic [W-1:0]     res  [4];

   for (genvar c = 0; c < 4; c++) begin : g_div
      logic [NUM_W-1:0] numer;

      assign numer = ({{(NUM_W-V_W){1'b0}}, mag_sq_ff[ROOT_W-1][c]} << (F + 1))
                   + NUM_W'(root);

      qmn_divide #(
         .NUM_W(NUM_W),
         .DEN_W(DEN_W),
         .QUO_W(QUO_W)
      ) u_divide (
         .clock (clock),
         .ctl   (ctl),
         .numer (numer),
         .denom ({root, 1'b0}),
         .quot  (quot[c])
      );

      assign res[c] = neg_dv_ff[QUO_W-1][c] ? W'(-W'(quot[c])) : W'(quot[c]);
   end

   // Output register; a degenerate request yields the identity quaternion.
   logic [W-1:0] out_ff [4];
   logic         deg_out_ff;

   always_ff @(posedge clock) begin
      if (enable) begin
         if (deg_dv_ff[QUO_W-1]) begin
            out_ff[0] <= '0;
            out_ff[1] <= '0;
            out_ff[2] <= '0;
            out_ff[3] <= W'(1) << F;
         end else begin
            out_ff <= res;
         end
         deg_out_ff <= deg_dv_ff[QUO_W-1];
      end
   end

   assign rsp_out_x      = out_ff[0];
   assign rsp_out_y      = out_ff[1];
   assign rsp_out_z      = out_ff[2];
   assign rsp_out_w      = out_ff[3];
   assign rsp_degenerate = deg_out_ff;

endmodule
